// ----- rtl/bba_pkg.sv -----
// Shared types, constants and codes of the block bitmap allocator.
`default_nettype none

package bba_pkg;

  localparam int POOL_SIZE_DEFAULT = 1024;
  localparam int WORD_BITS         = 32;
  localparam int BIT_W             = 5;
  localparam int NUM_W             = 16;
  localparam int FIRST_W           = 10;
  localparam int ENTRIES_W         = 11;
  localparam int CMP_W             = NUM_W + 1;
  localparam int APB_ADDR_W        = 4;
  localparam int APB_DATA_W        = 32;

  localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = ENTRIES_W'(1024);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    STATUS_GRANTED = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_FREED   = 2'd2,
    STATUS_IGNORED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_BASE_NUMBER    = 2'd0,
    REG_FIRST_INDEX    = 2'd1,
    REG_ENTRIES_IN_USE = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    req_type_t        req_type;
    logic [NUM_W-1:0] blk_num;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [NUM_W-1:0] granted_number;
  } rsp_t;

  // Range limits applied to one map word during a scan.
  typedef struct packed {
    logic             lo_en;
    logic [BIT_W-1:0] lo_bit;
    logic             hi_en;
    logic [BIT_W-1:0] hi_bit;
  } scan_mask_t;

endpackage

`default_nettype wire

// ----- rtl/bba_map_mem.sv -----
// Used-bit map storage: one write port and one registered read port.
`default_nettype none

module bba_map_mem #(
  parameter int WORDS = 32,
  parameter int WA_W  = 5
) (
  input  wire logic            clk,
  input  wire logic            rd_en,
  input  wire logic [WA_W-1:0] rd_addr,
  output bba_pkg::word_t       rd_data,
  input  wire logic            wr_en,
  input  wire logic [WA_W-1:0] wr_addr,
  input  wire bba_pkg::word_t  wr_data
);

  bba_pkg::word_t mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bba_find.sv -----
// First-clear-bit finder over one map word with range masking.
`default_nettype none

module bba_find (
  input  wire bba_pkg::word_t            data,
  input  wire bba_pkg::scan_mask_t       mask,
  output logic                           hit,
  output logic [bba_pkg::BIT_W-1:0]      pos,
  output bba_pkg::word_t                 lowest
);

  bba_pkg::word_t free_vec;

  always_comb begin
    for (int b = 0; b < bba_pkg::WORD_BITS; b++) begin
      free_vec[b] = !data[b]
                    && !(mask.lo_en && (bba_pkg::BIT_W'(b) < mask.lo_bit))
                    && !(mask.hi_en && (bba_pkg::BIT_W'(b) > mask.hi_bit));
    end
  end

  // Isolate the lowest free bit, then encode its position.
  assign lowest = free_vec & (~free_vec + bba_pkg::word_t'(1));
  assign hit    = |free_vec;

  always_comb begin
    pos = '0;
    for (int k = 0; k < bba_pkg::BIT_W; k++) begin
      for (int b = 0; b < bba_pkg::WORD_BITS; b++) begin
        if (((b >> k) & 1) == 1) begin
          pos[k] = pos[k] | lowest[b];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/block_bitmap_allocator.sv -----
// Top level of the first-fit block bitmap allocator.
`default_nettype none

// The allocator keeps one used bit per pool entry in a map memory of 32-bit
// words and handles one request transaction at a time. An allocate scans the
// map upward from first_index to the pool size in use, one word per cycle
// through the single read port, marks the first clear entry and returns
// base_number plus its index; with nothing free it returns status full and
// number 0. A free converts its number back to an index and clears that entry
// when first_index <= index < pool size, else it reports the request as
// ignored. An allocate goes from acceptance through the scan to delivery; a
// free inside the range goes through accept, read, write back and deliver,
// and a request answered without touching the map (an allocate on an empty
// range or an ignored free) goes from acceptance straight to delivery.
// After reset the block clears the map one word per cycle and holds
// req_stall high meanwhile; the APB port is usable at once. A finished
// result sits in an output register, so the next request transaction is
// taken while the previous result still waits on rsp_stall; only a result
// that finds that register still occupied holds the sequencer in its
// delivery cycle. Configuration must be written only while no request is
// in progress.
module block_bitmap_allocator #(
  parameter int POOL_SIZE = bba_pkg::POOL_SIZE_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Request channel
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire bba_pkg::req_t                 req,
  // Result channel
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output bba_pkg::rsp_t                      rsp,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bba_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [bba_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bba_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int WORDS = (POOL_SIZE + bba_pkg::WORD_BITS - 1) / bba_pkg::WORD_BITS;
  localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LIM_W = $clog2(POOL_SIZE + 1);
  localparam int CW    = (LIM_W > bba_pkg::ENTRIES_W) ? LIM_W : bba_pkg::ENTRIES_W;
  localparam logic [CW-1:0]   POOL_CW   = CW'(POOL_SIZE);
  localparam logic [WA_W-1:0] LAST_ADDR = WA_W'(WORDS - 1);

  // Configuration registers.
  logic [bba_pkg::NUM_W-1:0]     base_number;
  logic [bba_pkg::FIRST_W-1:0]   first_index;
  logic [bba_pkg::ENTRIES_W-1:0] entries_in_use;

  // Control and datapath registers.
  bba_pkg::state_t                state, state_next;
  logic [WA_W-1:0]                clr_word;
  logic [WA_W-1:0]                rd_word;
  logic [WA_W-1:0]                eval_word;
  logic                           data_ok;
  logic [WA_W-1:0]                free_word;
  logic [bba_pkg::BIT_W-1:0]      free_bit;
  bba_pkg::status_t               res_status;
  logic [bba_pkg::NUM_W-1:0]      res_number;

  // Memory port.
  logic            rd_en, wr_en;
  logic [WA_W-1:0] rd_addr, wr_addr;
  bba_pkg::word_t  rd_data, wr_data;

  // Finder.
  bba_pkg::scan_mask_t       mask;
  logic                      hit;
  logic [bba_pkg::BIT_W-1:0] hit_pos;
  bba_pkg::word_t            lowest;

  logic                      cfg_write;
  logic                      req_accept;
  logic                      load_rsp;
  logic [CW-1:0]             ent_cw;
  logic [LIM_W-1:0]          limit;
  logic [LIM_W-1:0]          limit_m1;
  logic [WA_W-1:0]           start_word;
  logic [WA_W-1:0]           last_word;
  logic                      alloc_empty;
  logic [bba_pkg::NUM_W-1:0] free_idx;
  logic                      free_ok;
  logic [WA_W+bba_pkg::BIT_W-1:0] hit_idx;

  // ---------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; reads are
  // answered from the registers directly.
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_number    <= '0;
      first_index    <= '0;
      entries_in_use <= bba_pkg::ENTRIES_RESET;
    end else if (cfg_write) begin
      unique case (bba_pkg::reg_idx_t'(paddr[3:2]))
        bba_pkg::REG_BASE_NUMBER:    base_number    <= pwdata[bba_pkg::NUM_W-1:0];
        bba_pkg::REG_FIRST_INDEX:    first_index    <= pwdata[bba_pkg::FIRST_W-1:0];
        bba_pkg::REG_ENTRIES_IN_USE: entries_in_use <= pwdata[bba_pkg::ENTRIES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (bba_pkg::reg_idx_t'(paddr[3:2]))
      bba_pkg::REG_BASE_NUMBER:    prdata = bba_pkg::APB_DATA_W'(base_number);
      bba_pkg::REG_FIRST_INDEX:    prdata = bba_pkg::APB_DATA_W'(first_index);
      bba_pkg::REG_ENTRIES_IN_USE: prdata = bba_pkg::APB_DATA_W'(entries_in_use);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pool range. The pool in use is the smaller of entries_in_use and the
  // POOL_SIZE parameter. The scan runs from the word holding first_index to
  // the word holding the last pool entry; edge words are masked bit by bit.
  // ---------------------------------------------------------------------
  assign ent_cw      = CW'(entries_in_use);
  assign limit       = LIM_W'((ent_cw < POOL_CW) ? ent_cw : POOL_CW);
  assign limit_m1    = limit - LIM_W'(1);
  assign start_word  = WA_W'(first_index >> bba_pkg::BIT_W);
  assign last_word   = WA_W'(limit_m1 >> bba_pkg::BIT_W);
  assign alloc_empty = bba_pkg::CMP_W'(first_index) >= bba_pkg::CMP_W'(limit);

  // A free maps its number back to an index with the same 16-bit wrap that
  // the allocation used.
  assign free_idx = req.blk_num - base_number;
  assign free_ok  = (free_idx >= bba_pkg::NUM_W'(first_index))
                    && (bba_pkg::CMP_W'(free_idx) < bba_pkg::CMP_W'(limit));

  assign mask.lo_en  = (eval_word == start_word);
  assign mask.lo_bit = first_index[bba_pkg::BIT_W-1:0];
  assign mask.hi_en  = (eval_word == last_word);
  assign mask.hi_bit = bba_pkg::BIT_W'(limit_m1);

  bba_find u_find (
    .data   (rd_data),
    .mask   (mask),
    .hit    (hit),
    .pos    (hit_pos),
    .lowest (lowest)
  );

  assign hit_idx = {eval_word, hit_pos};

  bba_map_mem #(
    .WORDS (WORDS),
    .WA_W  (WA_W)
  ) u_map_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // ---------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      bba_pkg::ST_CLEAR: begin
        if (clr_word == LAST_ADDR) begin
          state_next = bba_pkg::ST_IDLE;
        end
      end
      bba_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req.req_type == bba_pkg::REQ_ALLOC) begin
            state_next = alloc_empty ? bba_pkg::ST_DONE : bba_pkg::ST_SCAN;
          end else begin
            state_next = free_ok ? bba_pkg::ST_FREE_RD : bba_pkg::ST_DONE;
          end
        end
      end
      bba_pkg::ST_SCAN: begin
        if (data_ok && (hit || (eval_word == last_word))) begin
          state_next = bba_pkg::ST_DONE;
        end
      end
      bba_pkg::ST_FREE_RD: state_next = bba_pkg::ST_FREE_WR;
      bba_pkg::ST_FREE_WR: state_next = bba_pkg::ST_DONE;
      bba_pkg::ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = bba_pkg::ST_IDLE;
        end
      end
      default: state_next = bba_pkg::ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs. The scan issues one read per cycle and judges the
  // word read in the cycle before; a hit writes the word back with its bit
  // set in the same cycle.
  // ---------------------------------------------------------------------
  always_comb begin
    req_stall = 1'b1;
    rd_en     = 1'b0;
    rd_addr   = rd_word;
    wr_en     = 1'b0;
    wr_addr   = eval_word;
    wr_data   = rd_data | lowest;
    load_rsp  = 1'b0;
    unique case (state)
      bba_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_word;
        wr_data = '0;
      end
      bba_pkg::ST_IDLE: begin
        req_stall = 1'b0;
      end
      bba_pkg::ST_SCAN: begin
        rd_en = 1'b1;
        wr_en = data_ok && hit;
      end
      bba_pkg::ST_FREE_RD: begin
        rd_en   = 1'b1;
        rd_addr = free_word;
      end
      bba_pkg::ST_FREE_WR: begin
        wr_en   = 1'b1;
        wr_addr = free_word;
        wr_data = rd_data & ~(bba_pkg::word_t'(1) << free_bit);
      end
      bba_pkg::ST_DONE: begin
        load_rsp = !rsp_valid || !rsp_stall;
      end
      default: ;
    endcase
  end

  assign req_accept = req_valid && !req_stall;

  // ---------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bba_pkg::ST_CLEAR;
      clr_word  <= '0;
      data_ok   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (state == bba_pkg::ST_CLEAR) begin
        clr_word <= clr_word + WA_W'(1);
      end

      if (req_accept) begin
        data_ok <= 1'b0;
      end else if (state == bba_pkg::ST_SCAN) begin
        data_ok <= 1'b1;
      end

      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (req_accept) begin
      rd_word    <= start_word;
      free_word  <= WA_W'(free_idx >> bba_pkg::BIT_W);
      free_bit   <= free_idx[bba_pkg::BIT_W-1:0];
      res_number <= '0;
      if (req.req_type == bba_pkg::REQ_ALLOC) begin
        res_status <= bba_pkg::STATUS_FULL;
      end else if (free_ok) begin
        res_status <= bba_pkg::STATUS_FREED;
      end else begin
        res_status <= bba_pkg::STATUS_IGNORED;
      end
    end

    if (state == bba_pkg::ST_SCAN) begin
      rd_word   <= rd_word + WA_W'(1);
      eval_word <= rd_word;
      if (data_ok && hit) begin
        res_status <= bba_pkg::STATUS_GRANTED;
        res_number <= base_number + bba_pkg::NUM_W'(hit_idx);
      end
    end

    if (load_rsp) begin
      rsp.status         <= res_status;
      rsp.granted_number <= res_number;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_hit_ends_scan: assert property (@(posedge clk) disable iff (rst)
    (state == bba_pkg::ST_SCAN && data_ok && hit) |=> (state == bba_pkg::ST_DONE))
    else $error("scan did not finish after finding a free entry");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("map read and write hit the same word in one cycle");

  a_number_only_on_grant: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != bba_pkg::STATUS_GRANTED) |-> (rsp.granted_number == '0))
    else $error("nonzero number on a result that is not a grant");

  a_write_on_free: assert property (@(posedge clk) disable iff (rst)
    (state == bba_pkg::ST_FREE_RD) |=> (wr_en && wr_addr == $past(free_word)))
    else $error("free did not write back the word it read");

endmodule

`default_nettype wire
